FILE: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, codes and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_W       = 14;
    localparam int VAL_W       = 17;
    localparam int CAP_W       = 7;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int ADDR_W      = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } carry_t;

    typedef struct packed {
        logic match;
        logic done;
        logic evict;
    } cell_stat_t;

    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CAP_W'(1);
        end else if (c > CAP_W'(MAX_ENTRIES)) begin
            r = CAP_W'(MAX_ENTRIES);
        end
        return r;
    endfunction

endpackage

FILE: rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache kept in least-recently-used order.
//
// Input stream (s_*): s_tuser is the request type (0 get, 1 put), s_tdata
// carries key and value. Output stream (m_*): one result transaction per
// request with found, read value, evicted flag and evicted key.
// APB port: register 0 at address 0 is the capacity in use (reset 64).
//
// One request is processed at a time. After acceptance the row of cells is
// compared in the lookup state; the displaced entry then walks one cell per
// cycle from the front to the hit position, the first empty cell or the last
// cell of the capacity. When the walk stops, the result state loads the
// output register and the machine returns to idle to take the next request;
// a get miss skips the walk and goes from lookup straight to the result state.
// The result sits in the output register; a stalled receiver holds it there
// and the following request waits in its result cycle until the register
// frees, with the input held off meanwhile.
// Reset empties the cache and sets the capacity to 64; no clearing pass runs.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // key[13:0], value[30:14], zero pad
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // found[0], read_value[17:1],
                                             // evicted[18], evicted_key[32:19]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t           state_reg, state_next;
    logic             req_put_reg, req_put_next;
    logic [KEY_W-1:0] req_key_reg, req_key_next;
    logic [VAL_W-1:0] req_value_reg, req_value_next;
    logic             hit_reg, hit_next;
    logic [VAL_W-1:0] rd_value_reg, rd_value_next;
    logic             ev_reg, ev_next;
    logic [KEY_W-1:0] ev_key_reg, ev_key_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [CAP_W-1:0] cap_reg, cap_next;

    logic             cfg_wr;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] cap_new_eff;
    logic             lookup;
    logic             hit_any;
    logic [VAL_W-1:0] hit_value;
    logic             done_any;
    logic             evict_any;
    logic [KEY_W-1:0] evict_key;

    carry_t     carry_head;
    carry_t     carry_link [MAX_ENTRIES];
    cell_stat_t stat       [MAX_ENTRIES];
    entry_t     slot       [MAX_ENTRIES];
    logic       trim       [MAX_ENTRIES];
    logic       is_last    [MAX_ENTRIES];

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata   = (paddr[2] == REG_CAPACITY) ?
                      {{(APB_DATA_W-CAP_W){1'b0}}, cap_reg} : '0;
    assign cap_eff     = eff_cap(cap_reg);
    assign cap_new_eff = eff_cap(pwdata[CAP_W-1:0]);
    assign cap_next    = cfg_wr ? pwdata[CAP_W-1:0] : cap_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign lookup   = (state_reg == ST_LOOKUP);

    assign carry_head.valid = lookup && (hit_any || req_put_reg);
    assign carry_head.key   = req_key_reg;
    assign carry_head.value = (req_put_reg == REQ_PUT) ? req_value_reg : hit_value;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        assign trim[k]    = cfg_wr && (CAP_W'(k) >= cap_new_eff);
        assign is_last[k] = (CAP_W'(k) == (cap_eff - CAP_W'(1)));

        lkvc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lookup    (lookup),
            .req_key   (req_key_reg),
            .trim      (trim[k]),
            .is_last   (is_last[k]),
            .carry_in  ((k == 0) ? carry_head : carry_link[(k == 0) ? 0 : k - 1]),
            .carry_out (carry_link[k]),
            .stat      (stat[k]),
            .slot      (slot[k])
        );
    end

    always_comb begin
        hit_any   = 1'b0;
        hit_value = '0;
        done_any  = carry_link[MAX_ENTRIES-1].valid;
        evict_any = 1'b0;
        evict_key = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            hit_any   = hit_any | stat[k].match;
            hit_value = hit_value | ({VAL_W{stat[k].match}} & slot[k].value);
            done_any  = done_any | stat[k].done;
            evict_any = evict_any | stat[k].evict;
            evict_key = evict_key | ({KEY_W{stat[k].evict}} & slot[k].key);
        end
    end

    always_comb begin
        state_next     = state_reg;
        req_put_next   = req_put_reg;
        req_key_next   = req_key_reg;
        req_value_next = req_value_reg;
        hit_next       = hit_reg;
        rd_value_next  = rd_value_reg;
        ev_next        = ev_reg;
        ev_key_next    = ev_key_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_put_next   = s_tuser;
                    req_key_next   = s_tdata[KEY_W-1:0];
                    req_value_next = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    state_next     = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                hit_next      = hit_any;
                rd_value_next = (hit_any && (req_put_reg == REQ_GET)) ? hit_value : '0;
                ev_next       = 1'b0;
                ev_key_next   = '0;
                state_next    = carry_head.valid ? ST_SWEEP : ST_RESULT;
            end
            ST_SWEEP: begin
                if (done_any) begin
                    ev_next     = evict_any;
                    ev_key_next = evict_key;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({ev_key_reg, ev_reg, rd_value_reg, hit_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cap_reg      <= CAP_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cap_reg      <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_put_reg   <= req_put_next;
        req_key_reg   <= req_key_next;
        req_value_reg <= req_value_next;
        hit_reg       <= hit_next;
        rd_value_reg  <= rd_value_next;
        ev_reg        <= ev_next;
        ev_key_reg    <= ev_key_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

FILE: rtl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One position of the LRU row: holds an entry, matches the request key and
// swaps its entry with the carry that walks down the row.
// ----------------------------------------------------------------------------
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             lookup,
    input  logic [KEY_W-1:0] req_key,
    input  logic             trim,
    input  logic             is_last,
    input  carry_t           carry_in,
    output carry_t           carry_out,
    output cell_stat_t       stat,
    output entry_t           slot
);

    logic   valid_reg, valid_next;
    logic   match_reg, match_next;
    entry_t entry_reg, entry_next;
    logic   carry_valid_reg;
    entry_t carry_data_reg;
    logic   match_now;
    logic   active;

    assign match_now = valid_reg && (entry_reg.key == req_key);
    assign active    = carry_valid_reg;

    assign stat.match = match_now;
    assign stat.done  = active && (match_reg || !valid_reg || is_last);
    assign stat.evict = active && is_last && valid_reg && !match_reg;
    assign slot       = entry_reg;

    assign carry_out.valid = active && !stat.done;
    assign carry_out.key   = entry_reg.key;
    assign carry_out.value = entry_reg.value;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        match_next = lookup ? match_now : match_reg;
        if (trim) begin
            valid_next = 1'b0;
        end else if (active) begin
            valid_next       = 1'b1;
            entry_next.key   = carry_data_reg.key;
            entry_next.value = carry_data_reg.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            match_reg       <= 1'b0;
            carry_valid_reg <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            match_reg       <= match_next;
            carry_valid_reg <= carry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg            <= entry_next;
        carry_data_reg.key   <= carry_in.key;
        carry_data_reg.value <= carry_in.value;
    end

endmodule

FILE: rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_evict_only_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[18]))
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[18] |-> m_tdata[32:19] == '0)
        else $error("evicted key set without eviction");

    a_value_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:1] != '0) |-> m_tdata[0])
        else $error("read value returned on a miss");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken before the first finished");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
